[rtl/pts_sfq_pkg.sv]
package pts_sfq_pkg;

    localparam int DEPTH      = 32;
    localparam int TAG_WIDTH  = 16;
    localparam int PTS_W      = 64;
    localparam int IO_TAG_W   = 16;
    localparam int LEVEL_W    = 6;
    localparam int CAP_W      = 6;
    localparam int KIND_W     = 2;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(30);

    // command codes
    localparam logic [KIND_W-1:0] KIND_PUSH         = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP          = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR        = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR_NONKEY = 2'd3;

    typedef struct packed {
        logic signed [PTS_W-1:0] pts;
        logic                    key;
        logic [TAG_WIDTH-1:0]    tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [PTS_W-1:0] new_pts;
        logic                    key_frame;
        logic [IO_TAG_W-1:0]     frame_tag;
    } t_item;

    typedef struct packed {
        logic                    popped_valid;
        logic signed [PTS_W-1:0] popped_pts;
        logic                    popped_key;
        logic [IO_TAG_W-1:0]     popped_tag;
        logic                    evicted;
        logic [IO_TAG_W-1:0]     evicted_tag;
        logic                    empty_error;
        logic [LEVEL_W-1:0]      level;
        logic                    head_valid;
        logic signed [PTS_W-1:0] head_pts;
        logic                    head_key;
        logic [IO_TAG_W-1:0]     head_tag;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

[rtl/pts_sfq_if.sv]
interface pts_sfq_item_if;
    logic                                         valid;
    logic                                         ready;
    logic [pts_sfq_pkg::KIND_W-1:0]               kind;
    logic signed [pts_sfq_pkg::PTS_W-1:0]         new_pts;
    logic                                         key_frame;
    logic [pts_sfq_pkg::IO_TAG_W-1:0]             frame_tag;

    modport source (output valid, kind, new_pts, key_frame, frame_tag, input ready);
    modport sink   (input valid, kind, new_pts, key_frame, frame_tag, output ready);
endinterface

interface pts_sfq_result_if;
    logic                                         valid;
    logic                                         ready;
    logic                                         popped_valid;
    logic signed [pts_sfq_pkg::PTS_W-1:0]         popped_pts;
    logic                                         popped_key;
    logic [pts_sfq_pkg::IO_TAG_W-1:0]             popped_tag;
    logic                                         evicted;
    logic [pts_sfq_pkg::IO_TAG_W-1:0]             evicted_tag;
    logic                                         empty_error;
    logic [pts_sfq_pkg::LEVEL_W-1:0]              level;
    logic                                         head_valid;
    logic signed [pts_sfq_pkg::PTS_W-1:0]         head_pts;
    logic                                         head_key;
    logic [pts_sfq_pkg::IO_TAG_W-1:0]             head_tag;

    modport source (output valid, popped_valid, popped_pts, popped_key, popped_tag,
                    evicted, evicted_tag, empty_error, level, head_valid, head_pts,
                    head_key, head_tag, input ready);
    modport sink   (input valid, popped_valid, popped_pts, popped_key, popped_tag,
                    evicted, evicted_tag, empty_error, level, head_valid, head_pts,
                    head_key, head_tag, output ready);
endinterface

interface pts_sfq_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pts_sfq_pkg::CAP_W-1:0]      capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

[rtl/pts_sfq_ram.sv]
module pts_sfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pts_sfq_engine.sv]
module pts_sfq_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  pts_sfq_pkg::t_item            i_item,
    input  logic [pts_sfq_pkg::CAP_W-1:0] i_capacity,
    input  logic                          i_take,
    output pts_sfq_pkg::t_eng_stat        o_stat,
    output pts_sfq_pkg::t_result          o_result
);

    localparam int DEPTH = pts_sfq_pkg::DEPTH;
    localparam int AW    = pts_sfq_pkg::AW;
    localparam int CW    = pts_sfq_pkg::CW;
    localparam int SW    = AW + 1;
    localparam int TW    = pts_sfq_pkg::TAG_WIDTH;
    localparam int OTW   = pts_sfq_pkg::IO_TAG_W;
    localparam int LW    = pts_sfq_pkg::LEVEL_W;
    localparam int EW    = pts_sfq_pkg::ENTRY_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_EVICT_RD, S_INS_START, S_INS, S_INS_LAST,
        S_POP_RD, S_KEEP, S_HEAD, S_HEAD_RD, S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [pts_sfq_pkg::KIND_W-1:0] r_kind, n_kind;
    pts_sfq_pkg::t_entry   r_new, n_new;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_k, n_k;
    logic [CW-1:0]         r_w, n_w;
    pts_sfq_pkg::t_result  r_res, n_res;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    pts_sfq_pkg::t_entry   ram_wdata, ram_rdata;
    logic [EW-1:0]         ram_rbits;
    logic [CW-1:0]         eff_cap;

    // logical slot -> physical address, ring starting at r_head
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    pts_sfq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(ram_wdata)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = pts_sfq_pkg::t_entry'(ram_rbits);

    // capacity clamped to 1..DEPTH
    always_comb begin
        if (i_capacity == '0) begin
            eff_cap = CW'(1);
        end else if (int'(i_capacity) > DEPTH) begin
            eff_cap = CW'(DEPTH);
        end else begin
            eff_cap = CW'(i_capacity);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_new     = r_new;
        n_head    = r_head;
        n_count   = r_count;
        n_k       = r_k;
        n_w       = r_w;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = phys(r_head, r_k + CW'(1));
        ram_wdata = r_new;
        ram_re    = 1'b0;
        ram_raddr = phys(r_head, '0);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind    = i_item.kind;
                    n_new.pts = i_item.new_pts;
                    n_new.key = i_item.key_frame;
                    n_new.tag = TW'(i_item.frame_tag);
                    n_res     = '0;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_kind)
                    pts_sfq_pkg::KIND_PUSH: begin
                        if (r_count >= eff_cap && r_count != '0) begin
                            ram_re  = 1'b1;
                            n_state = S_EVICT_RD;
                        end else begin
                            n_state = S_INS_START;
                        end
                    end
                    pts_sfq_pkg::KIND_POP: begin
                        if (r_count == '0) begin
                            n_res.empty_error = 1'b1;
                            n_state = S_HEAD;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = S_POP_RD;
                        end
                    end
                    pts_sfq_pkg::KIND_CLEAR: begin
                        n_count = '0;
                        n_state = S_HEAD;
                    end
                    default: begin
                        n_k = '0;
                        n_w = '0;
                        if (r_count == '0) begin
                            n_state = S_HEAD;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = S_KEEP;
                        end
                    end
                endcase
            end
            S_EVICT_RD: begin
                n_res.evicted     = 1'b1;
                n_res.evicted_tag = OTW'(ram_rdata.tag);
                n_head            = phys(r_head, CW'(1));
                n_count           = r_count - CW'(1);
                n_state           = S_INS_START;
            end
            S_INS_START: begin
                n_count = r_count + CW'(1);
                if (r_count == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(r_head, '0);
                    n_state   = S_HEAD;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = phys(r_head, r_count - CW'(1));
                    n_k       = r_count - CW'(1);
                    n_state   = S_INS;
                end
            end
            S_INS: begin
                // walk down from the tail, moving larger entries up one slot
                ram_we = 1'b1;
                if ($signed(r_new.pts) < $signed(ram_rdata.pts)) begin
                    ram_wdata = ram_rdata;
                    if (r_k == '0) begin
                        n_state = S_INS_LAST;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = phys(r_head, r_k - CW'(1));
                        n_k       = r_k - CW'(1);
                    end
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_INS_LAST: begin
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, '0);
                n_state   = S_HEAD;
            end
            S_POP_RD: begin
                n_res.popped_valid = 1'b1;
                n_res.popped_pts   = ram_rdata.pts;
                n_res.popped_key   = ram_rdata.key;
                n_res.popped_tag   = OTW'(ram_rdata.tag);
                n_head             = phys(r_head, CW'(1));
                n_count            = r_count - CW'(1);
                n_state            = S_HEAD;
            end
            S_KEEP: begin
                // compaction: read slot r_k, write key frames to slot r_w
                if (ram_rdata.key) begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(r_head, r_w);
                    ram_wdata = ram_rdata;
                    n_w       = r_w + CW'(1);
                end
                if (r_k + CW'(1) == r_count) begin
                    n_count = n_w;
                    n_state = S_HEAD;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = phys(r_head, r_k + CW'(1));
                    n_k       = r_k + CW'(1);
                end
            end
            S_HEAD: begin
                n_res.level = LW'(r_count);
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                n_res.head_valid = 1'b1;
                n_res.head_pts   = ram_rdata.pts;
                n_res.head_key   = ram_rdata.key;
                n_res.head_tag   = OTW'(ram_rdata.tag);
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
        r_kind <= n_kind;
        r_new  <= n_new;
        r_k    <= n_k;
        r_w    <= n_w;
        r_res  <= n_res;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_result    = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("fill count above depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> ram_waddr != ram_raddr)
        else $error("read and write of one slot in one cycle");

    a_ins_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> r_k < r_count)
        else $error("insert walk outside held entries");

    a_head_matches_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_res.head_valid == (r_count != '0))
        else $error("head valid disagrees with fill level");

endmodule

[rtl/pts_sorted_frame_queue_top.sv]
// Sorted frame queue: holds up to DEPTH frame descriptors (timestamp, key
// flag, tag) in ascending timestamp order; equal timestamps keep arrival order.
//
// Channels:
//   i_item   - one command per transfer: push, pop, clear all, clear non-key.
//   o_result - exactly one result per command: popped frame, evicted tag,
//              empty error, fill level and the head after the command.
//   i_cfg    - capacity register; always ready, write it only when idle.
//
// Operation: one command at a time; the next one is taken in the cycle its
// result appears. A push walks down from the tail over each held entry with a
// larger timestamp, after evicting the head first if the queue is at capacity.
// Clear non-key reads every held entry once and writes back the key frames.
// One 1R1W RAM holds all entries, so a walk moves one entry a cycle.
//
// Reset: queue empty, capacity 30. No clearing pass; slots are read only
// after being written. A stalled o_result holds its transfer; the next
// command is still accepted and runs, then waits for the output register.
module pts_sorted_frame_queue_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    pts_sfq_item_if.sink            i_item,
    pts_sfq_result_if.source        o_result,
    pts_sfq_cfg_if.sink             i_cfg
);

    logic [pts_sfq_pkg::CAP_W-1:0] r_capacity;
    pts_sfq_pkg::t_item            item;
    pts_sfq_pkg::t_eng_stat        stat;
    pts_sfq_pkg::t_result          eng_res;
    pts_sfq_pkg::t_result          r_out;
    logic                          r_out_valid;
    logic                          take;

    assign item.kind      = i_item.kind;
    assign item.new_pts   = i_item.new_pts;
    assign item.key_frame = i_item.key_frame;
    assign item.frame_tag = i_item.frame_tag;

    // engine only takes a command when idle
    assign i_item.ready = stat.idle;
    assign i_cfg.ready  = 1'b1;

    // output register is free, or its transfer completes this cycle
    assign take = !r_out_valid || o_result.ready;

    pts_sfq_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_item.valid && stat.idle),
        .i_item     (item),
        .i_capacity (r_capacity),
        .i_take     (take),
        .o_stat     (stat),
        .o_result   (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= pts_sfq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_capacity <= i_cfg.capacity;
            end
            if (stat.done && take) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (stat.done && take) begin
            r_out <= eng_res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.popped_valid = r_out.popped_valid;
    assign o_result.popped_pts   = r_out.popped_pts;
    assign o_result.popped_key   = r_out.popped_key;
    assign o_result.popped_tag   = r_out.popped_tag;
    assign o_result.evicted      = r_out.evicted;
    assign o_result.evicted_tag  = r_out.evicted_tag;
    assign o_result.empty_error  = r_out.empty_error;
    assign o_result.level        = r_out.level;
    assign o_result.head_valid   = r_out.head_valid;
    assign o_result.head_pts     = r_out.head_pts;
    assign o_result.head_key     = r_out.head_key;
    assign o_result.head_tag     = r_out.head_tag;

endmodule
